/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the frame checker RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, disabled while reset is asserted (active low).
`define FCHK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Same-cycle implication, disabled while reset is asserted (active low).
`define FCHK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/fchk_pkg.sv */
// ----------------------------------------------------------------------------
// Frame checker package
// Types, codes and CRC helpers shared by the frame checker modules.
// ----------------------------------------------------------------------------
package fchk_pkg;

  localparam logic       MODE_HEADER  = 1'b0;
  localparam logic       MODE_PAYLOAD = 1'b1;

  localparam logic       CFG_SYNC_WORD = 1'b0;
  localparam logic       CFG_MAX_LEN   = 1'b1;

  localparam logic [7:0]  CRC8_POLY   = 8'h07;
  localparam logic [7:0]  CRC8_INIT   = 8'h00;
  localparam logic [15:0] CRC16_POLY  = 16'h1021;
  localparam logic [15:0] CRC16_INIT  = 16'hFFFF;
  localparam logic [15:0] MAX_LEN_RST = 16'd1016;

  typedef enum logic [2:0] {
    ERR_OK     = 3'd0,
    ERR_SYNC   = 3'd1,
    ERR_LENGTH = 3'd2,
    ERR_HCRC   = 3'd3,
    ERR_PCRC   = 3'd4
  } err_code_e;

  typedef struct packed {
    logic        mode;
    logic [15:0] sync_value;
    logic [7:0]  frame_type;
    logic [15:0] payload_length;
    logic [7:0]  header_check;
    logic [15:0] payload_check;
    logic [7:0]  payload_byte;
  } item_t;

  typedef struct packed {
    logic      frame_ok;
    err_code_e error_code;
  } result_t;

  // CRC-8, MSB first, one byte.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC8_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // CRC-16-CCITT, MSB first, one byte.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* rtl/frame_header_payload_crc_checker.sv */
// ----------------------------------------------------------------------------
// Frame header and payload CRC checker
// Checks frame headers (sync, length, CRC-8) and payload CRC-16-CCITT.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o): one request per header or
//    payload byte; mode_i selects which. Accepted when valid and not stall.
//  - Output channel (out_valid_o / out_stall_i): zero or one result per
//    request: frame_ok_o and error_code_o. Failed headers report at once;
//    a frame reports after its last payload byte. Passing headers and
//    stray payload bytes give no result.
//  - Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//    (0 sync word, 1 max payload length). Write only while idle.
//  - Path: the accepting edge loads the input register; the result is
//    loaded into the result register as the pipeline advances.
//  - Throughput: one request per cycle when no stalled result holds the
//    pipeline; the CRC-16 byte update and header checks sit in one
//    combinational stage between the two registers.
//  - Reset: no frame open, CRC at 0xFFFF, sync word 0, max length 1016,
//    both pipeline stages empty.
//  - Stall: a stalled result holds; the input register still fills, and the
//    input stalls only once a request waits behind a stalled result.
// ----------------------------------------------------------------------------
module frame_header_payload_crc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [15:0] sync_value_i,
  input  logic [7:0]  frame_type_i,
  input  logic [15:0] payload_length_i,
  input  logic [7:0]  header_check_i,
  input  logic [15:0] payload_check_i,
  input  logic [7:0]  payload_byte_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        frame_ok_o,
  output logic [2:0]  error_code_o
);
  import fchk_pkg::*;

  logic [15:0] sync_word_q;
  logic [15:0] max_len_q;

  item_t   in_item;
  item_t   s1_item;
  logic    s1_vld;
  logic    adv;
  logic    res_vld;
  result_t res;
  result_t out_res;

  // Config registers, plain decoded write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q <= '0;
      max_len_q   <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYNC_WORD: sync_word_q <= cfg_wdata_i;
        CFG_MAX_LEN:   max_len_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_item = '{mode:           mode_i,
                     sync_value:     sync_value_i,
                     frame_type:     frame_type_i,
                     payload_length: payload_length_i,
                     header_check:   header_check_i,
                     payload_check:  payload_check_i,
                     payload_byte:   payload_byte_i};

  // Stage 1: request register.
  fchk_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .adv_i      (adv),
    .vld_o      (s1_vld),
    .item_o     (s1_item)
  );

  // Checks and frame state; state updates as the request moves on.
  fchk_frame_ctrl u_frame_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (s1_vld),
    .item_i      (s1_item),
    .adv_i       (adv),
    .sync_word_i (sync_word_q),
    .max_len_i   (max_len_q),
    .res_vld_o   (res_vld),
    .res_o       (res)
  );

  // Stage 2: result register.
  fchk_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_vld_i   (res_vld),
    .res_i       (res),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign frame_ok_o   = out_res.frame_ok;
  assign error_code_o = out_res.error_code;

endmodule

/* rtl/fchk_in_stage.sv */
// ----------------------------------------------------------------------------
// Frame checker input stage
// Registers one request and holds it until the pipeline advances.
// ----------------------------------------------------------------------------
module fchk_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fchk_pkg::item_t item_i,
  input  logic          adv_i,
  output logic          vld_o,
  output fchk_pkg::item_t item_o
);
  import fchk_pkg::*;

  logic  vld_q, vld_d;
  item_t item_q;

  // Stage is blocked only when it holds a request the next stage cannot take.
  assign in_stall_o = vld_q & ~adv_i;

  always_comb begin
    vld_d = vld_q;
    if (!in_stall_o) begin
      vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

/* rtl/fchk_frame_ctrl.sv */
// ----------------------------------------------------------------------------
// Frame checker control
// Header checks, frame state and payload CRC-16 update for one request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fchk_frame_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  fchk_pkg::item_t   item_i,
  input  logic              adv_i,
  input  logic [15:0]       sync_word_i,
  input  logic [15:0]       max_len_i,
  output logic              res_vld_o,
  output fchk_pkg::result_t res_o
);
  import fchk_pkg::*;

  logic        open_q, open_d;
  logic [15:0] left_q, left_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] exp_q, exp_d;

  logic        fire;
  logic [7:0]  hdr_crc;
  logic [15:0] crc_nxt;
  logic [15:0] left_m1;

  assign fire = vld_i & adv_i;

  // Header CRC-8 over sync_hi, sync_lo, type, len_hi, len_lo.
  assign hdr_crc = crc8_byte(crc8_byte(crc8_byte(crc8_byte(crc8_byte(CRC8_INIT,
                     item_i.sync_value[15:8]), item_i.sync_value[7:0]),
                     item_i.frame_type), item_i.payload_length[15:8]),
                     item_i.payload_length[7:0]);

  assign crc_nxt = crc16_byte(crc_q, item_i.payload_byte);
  assign left_m1 = left_q - 16'd1;

  always_comb begin
    open_d    = open_q;
    left_d    = left_q;
    crc_d     = crc_q;
    exp_d     = exp_q;
    res_vld_o = 1'b0;
    res_o     = '{frame_ok: 1'b0, error_code: ERR_OK};
    if (fire) begin
      if (item_i.mode == MODE_HEADER) begin
        // a header always drops any open frame
        open_d = 1'b0;
        left_d = '0;
        crc_d  = CRC16_INIT;
        if (item_i.sync_value != sync_word_i) begin
          res_vld_o        = 1'b1;
          res_o.error_code = ERR_SYNC;
        end else if (item_i.payload_length == '0 || item_i.payload_length > max_len_i) begin
          res_vld_o        = 1'b1;
          res_o.error_code = ERR_LENGTH;
        end else if (hdr_crc != item_i.header_check) begin
          res_vld_o        = 1'b1;
          res_o.error_code = ERR_HCRC;
        end else begin
          open_d = 1'b1;
          left_d = item_i.payload_length;
          exp_d  = item_i.payload_check;
        end
      end else if (open_q) begin
        crc_d  = crc_nxt;
        left_d = left_m1;
        if (left_m1 == '0) begin
          open_d         = 1'b0;
          crc_d          = CRC16_INIT;
          res_vld_o      = 1'b1;
          res_o.frame_ok = (crc_nxt == exp_q);
          res_o.error_code = (crc_nxt == exp_q) ? ERR_OK : ERR_PCRC;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      left_q <= '0;
      crc_q  <= CRC16_INIT;
      exp_q  <= '0;
    end else begin
      open_q <= open_d;
      left_q <= left_d;
      crc_q  <= crc_d;
      exp_q  <= exp_d;
    end
  end

  `FCHK_ASSERT_IMP(a_open_has_bytes, clk_i, rst_ni, open_q, left_q != '0, "open frame with no bytes left")
  `FCHK_ASSERT_IMP(a_idle_crc_init, clk_i, rst_ni, !open_q, crc_q == CRC16_INIT, "CRC not re-initialised")
  `FCHK_ASSERT_IMP(a_ok_matches_code, clk_i, rst_ni, res_vld_o, res_o.frame_ok == (res_o.error_code == ERR_OK), "frame_ok disagrees with code")
  `FCHK_ASSERT(a_no_result_idle, clk_i, rst_ni, !fire |-> !res_vld_o, "result without a request")

endmodule

/* rtl/fchk_out_stage.sv */
// ----------------------------------------------------------------------------
// Frame checker output stage
// Result register and pipeline advance control.
// ----------------------------------------------------------------------------
module fchk_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_vld_i,
  input  fchk_pkg::result_t res_i,
  output logic              adv_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fchk_pkg::result_t res_o
);
  import fchk_pkg::*;

  logic    vld_q, vld_d;
  result_t res_q;

  // Pipeline moves when the result register is empty or being drained.
  assign adv_o = ~vld_q | ~out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (adv_o) begin
      vld_d = res_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

/* sim/frame_header_payload_crc_checker_test.sv */
// ----------------------------------------------------------------------------
// Frame checker regression bench
// Drives header and payload requests into the frame checker. Random idling is
// applied on both handshakes. A frame verdict scoreboard predicts each sync,
// length, header CRC-8 and payload CRC-16 verdict and checks the results in
// order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_header_payload_crc_checker_test;
  import fchk_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 6;     // pipeline is two stages deep
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int unsigned SEGMENT_ITEMS  = 325;   // six segments, roughly 1950 requests

  // --------------------------------------------------------------------------
  // Frame verdict scoreboard: its own copy of the registers and of the frame
  // state, plus the queue of verdicts still owed by the block.
  // --------------------------------------------------------------------------
  class frame_verdict_board;
    logic [15:0] sync_reg;
    logic [15:0] max_len_reg;
    bit          open_frame;
    logic [15:0] bytes_to_go;
    logic [15:0] crc_run;
    logic [15:0] crc_want;
    result_t     verdicts[$];
    int unsigned errors;

    function new();
      sync_reg    = 16'h0000;
      max_len_reg = MAX_LEN_RST;
      open_frame  = 1'b0;
      bytes_to_go = 16'h0000;
      crc_run     = CRC16_INIT;
      crc_want    = 16'h0000;
      errors      = 0;
    endfunction

    // CRC-8 over sync, type and length, fed one bit at a time, MSB first
    static function logic [7:0] calc_hdr_crc8(logic [15:0] sync, logic [7:0] ftype,
                                              logic [15:0] len);
      logic [39:0] hdr;
      logic [7:0]  c;
      hdr = {sync, ftype, len};
      c   = CRC8_INIT;
      for (int i = 39; i >= 0; i--)
        c = {c[6:0], 1'b0} ^ ((c[7] ^ hdr[i]) ? CRC8_POLY : 8'h00);
      return c;
    endfunction

    static function logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] data);
      logic [15:0] c;
      c = crc;
      for (int i = 7; i >= 0; i--)
        c = {c[14:0], 1'b0} ^ ((c[15] ^ data[i]) ? CRC16_POLY : 16'h0000);
      return c;
    endfunction

    function void set_register(logic idx, logic [15:0] value);
      if (idx == CFG_SYNC_WORD) sync_reg = value;
      else max_len_reg = value;
    endfunction

    function int unsigned outstanding();
      return verdicts.size();
    endfunction

    // Note one accepted request and queue the verdict it causes, if any
    function void note_request(item_t req);
      result_t v;
      bit      report;
      report     = 1'b0;
      v.frame_ok = 1'b0;
      v.error_code = ERR_OK;
      if (req.mode == MODE_HEADER) begin
        // a header always drops whatever frame was open
        open_frame  = 1'b0;
        bytes_to_go = 16'h0000;
        crc_run     = CRC16_INIT;
        report      = 1'b1;
        if (req.sync_value != sync_reg) begin
          v.error_code = ERR_SYNC;
        end else if (req.payload_length == 16'h0000 || req.payload_length > max_len_reg) begin
          v.error_code = ERR_LENGTH;
        end else if (calc_hdr_crc8(req.sync_value, req.frame_type, req.payload_length)
                     != req.header_check) begin
          v.error_code = ERR_HCRC;
        end else begin
          report      = 1'b0;
          open_frame  = 1'b1;
          bytes_to_go = req.payload_length;
          crc_want    = req.payload_check;
        end
      end else if (open_frame) begin
        crc_run     = crc16_update(crc_run, req.payload_byte);
        bytes_to_go = bytes_to_go - 16'd1;
        if (bytes_to_go == 16'h0000) begin
          report       = 1'b1;
          open_frame   = 1'b0;
          v.frame_ok   = (crc_run == crc_want);
          v.error_code = v.frame_ok ? ERR_OK : ERR_PCRC;
          crc_run      = CRC16_INIT;
        end
      end
      if (report) verdicts.push_back(v);
    endfunction

    function void check_result(logic ok, logic [2:0] code);
      result_t want;
      if (verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual frame_ok %0b error_code %0d",
                 $time, ok, code);
        return;
      end
      want = verdicts.pop_front();
      if (ok !== want.frame_ok) begin
        errors++;
        $display("%0t: frame_ok mismatch, expected %0b, actual %0b", $time, want.frame_ok, ok);
      end
      if (code !== want.error_code) begin
        errors++;
        $display("%0t: error_code mismatch, expected %0d, actual %0d",
                 $time, want.error_code, code);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block hook-up. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        cfg_we_i         = 1'b0;
  logic        cfg_idx_i        = CFG_SYNC_WORD;
  logic [15:0] cfg_wdata_i      = 16'h0000;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic        mode_i           = MODE_HEADER;
  logic [15:0] sync_value_i     = 16'h0000;
  logic [7:0]  frame_type_i     = 8'h00;
  logic [15:0] payload_length_i = 16'h0000;
  logic [7:0]  header_check_i   = 8'h00;
  logic [15:0] payload_check_i  = 16'h0000;
  logic [7:0]  payload_byte_i   = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic        frame_ok_o;
  logic [2:0]  error_code_o;

  frame_header_payload_crc_checker dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .sync_value_i     (sync_value_i),
    .frame_type_i     (frame_type_i),
    .payload_length_i (payload_length_i),
    .header_check_i   (header_check_i),
    .payload_check_i  (payload_check_i),
    .payload_byte_i   (payload_byte_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_ok_o       (frame_ok_o),
    .error_code_o     (error_code_o)
  );

  frame_verdict_board board;
  int unsigned        send_idle_pct = 35;
  int unsigned        recv_idle_pct = 47;
  int unsigned        counted_items = 0;
  int unsigned        quiet_cycles  = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Result side: stall decided at the falling edge, so it is settled by the
  // rising edge at which the block looks at it.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Monitor: every handshake is observed here, in one process, so the order
  // of noting requests and checking results never depends on the simulator.
  // It also runs the watchdog on cycles where nothing moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        board.note_request({mode_i, sync_value_i, frame_type_i, payload_length_i,
                            header_check_i, payload_check_i, payload_byte_i});
      if (out_valid_o && !out_stall_i)
        board.check_result(frame_ok_o, error_code_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d verdicts outstanding",
                 $time, board.outstanding());
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side. Tasks are entered and left at a falling edge.
  // --------------------------------------------------------------------------
  function automatic item_t random_request();
    item_t r;
    r.mode           = 1'($urandom_range(1));
    r.sync_value     = 16'($urandom_range(65535));
    r.frame_type     = 8'($urandom_range(255));
    r.payload_length = 16'($urandom_range(65535));
    r.header_check   = 8'($urandom_range(255));
    r.payload_check  = 16'($urandom_range(65535));
    r.payload_byte   = 8'($urandom_range(255));
    return r;
  endfunction

  // Present one request, idling first at random, and hold it until taken.
  // Valid stays high into the next request when there is no gap.
  task automatic send_request(input item_t req, input bit counts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    mode_i           <= req.mode;
    sync_value_i     <= req.sync_value;
    frame_type_i     <= req.frame_type;
    payload_length_i <= req.payload_length;
    header_check_i   <= req.header_check;
    payload_check_i  <= req.payload_check;
    payload_byte_i   <= req.payload_byte;
    do @(posedge clk_i); while (in_stall_o);
    if (counts) counted_items++;
    @(negedge clk_i);
  endtask

  // Wait until every verdict is in, then let the pipeline empty; a passing
  // header or a stray byte may still be in flight with nothing owed for it.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (board.outstanding() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_registers(input logic [15:0] sync, input logic [15:0] max_len);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SYNC_WORD;
    cfg_wdata_i <= sync;
    board.set_register(CFG_SYNC_WORD, sync);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_MAX_LEN;
    cfg_wdata_i <= max_len;
    board.set_register(CFG_MAX_LEN, max_len);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_header(input logic [15:0] sync, input logic [7:0] ftype,
                             input logic [15:0] len, input bit crc_good,
                             input logic [15:0] pchk);
    item_t      req;
    logic [7:0] hchk;
    hchk = frame_verdict_board::calc_hdr_crc8(sync, ftype, len);
    if (!crc_good) hchk = hchk ^ 8'($urandom_range(1, 255));
    req                = random_request();
    req.mode           = MODE_HEADER;
    req.sync_value     = sync;
    req.frame_type     = ftype;
    req.payload_length = len;
    req.header_check   = hchk;
    req.payload_check  = pchk;
    send_request(req, 1'b1);
  endtask

  // Payload byte: every other field is junk the block must ignore
  task automatic send_byte(input logic [7:0] data, input bit counts);
    item_t req;
    req              = random_request();
    req.mode         = MODE_PAYLOAD;
    req.payload_byte = data;
    send_request(req, counts);
  endtask

  // Header with random fields; half the time the right sync and, on its own, half
  // the time a legal length, so the header CRC check gets exercised too
  task automatic send_noise_header();
    item_t req;
    req      = random_request();
    req.mode = MODE_HEADER;
    if ($urandom_range(1)) req.sync_value = board.sync_reg;
    if ($urandom_range(1)) req.payload_length = 16'($urandom_range(1, board.max_len_reg));
    send_request(req, 1'b1);
  endtask

  // Complete frame with a clean header; the payload CRC is right or spoilt
  task automatic send_frame(input logic [15:0] len, input bit crc_good);
    logic [7:0]  body[$];
    logic [15:0] crc;
    crc = CRC16_INIT;
    for (int i = 0; i < int'(len); i++) begin
      body.push_back(8'($urandom_range(255)));
      crc = frame_verdict_board::crc16_update(crc, body[i]);
    end
    if (!crc_good) crc = crc ^ 16'($urandom_range(1, 65535));
    send_header(board.sync_reg, 8'($urandom_range(255)), len, 1'b1, crc);
    foreach (body[i]) send_byte(body[i], 1'b1);
  endtask

  task automatic run_directed();
    // stray byte with no frame open: dropped, nothing owed
    send_byte(8'hFF, 1'b1);
    // each header check on its own, then precedence between them
    send_header(16'hFFFF, 8'h00, 16'd1, 1'b1, 16'h0000);
    send_header(16'h0000, 8'hFF, 16'd0, 1'b1, 16'hFFFF);
    send_header(16'h0000, 8'h5A, 16'd1017, 1'b1, 16'h0000);
    send_header(16'h0000, 8'hA5, 16'd1016, 1'b0, 16'h0000);
    send_header(16'h1234, 8'h00, 16'd0, 1'b0, 16'h0000);
    send_header(16'h0000, 8'h00, 16'd0, 1'b0, 16'h0000);
    // good frame, then a payload CRC mismatch
    send_frame(16'd2, 1'b1);
    send_frame(16'd1, 1'b0);
    // header arriving mid-frame drops the open frame
    send_header(16'h0000, 8'h3C, 16'd3, 1'b1, 16'hFFFF);
    send_byte(8'($urandom_range(255)), 1'b1);
    send_header(16'h1234, 8'hC3, 16'd3, 1'b1, 16'h0000);

    // widest settings: longest length opens a frame, cut short by a new one
    drain_results();
    write_registers(16'hFFFF, 16'hFFFF);
    send_header(16'hFFFF, 8'h81, 16'hFFFF, 1'b1, 16'h0000);
    send_byte(8'($urandom_range(255)), 1'b1);
    send_byte(8'($urandom_range(255)), 1'b1);
    send_frame(16'd3, 1'b1);

    // a zero maximum refuses every header on length
    drain_results();
    write_registers(16'hFFFF, 16'h0000);
    send_header(16'hFFFF, 8'h18, 16'd1, 1'b1, 16'h0000);

    // smallest legal maximum: length one passes, length two does not
    drain_results();
    write_registers(16'hFFFF, 16'd1);
    send_frame(16'd1, 1'b1);
    send_header(16'hFFFF, 8'h7E, 16'd2, 1'b1, 16'h0000);
  endtask

  // One random sequence: mostly complete frames, most with a good payload CRC,
  // the rest truncated frames, bad headers, junk headers and stray bytes
  task automatic send_random_sequence();
    int unsigned pick;
    int unsigned m;
    int unsigned len;
    int unsigned cut;
    m    = {16'h0000, board.max_len_reg};
    pick = $urandom_range(99);
    if (pick < 60) begin
      if ($urandom_range(19) == 0) len = $urandom_range(1, (m < 200) ? m : 200);
      else len = $urandom_range(1, (m < 12) ? m : 12);
      send_frame(16'(len), $urandom_range(3) != 0);
    end else if (pick < 70) begin
      // truncated frame, any legal length, closed by the next header
      len = $urandom_range(1, m);
      cut = $urandom_range(0, (len - 1 < 5) ? len - 1 : 5);
      send_header(board.sync_reg, 8'($urandom_range(255)), 16'(len), 1'b1,
                  16'($urandom_range(65535)));
      repeat (cut) send_byte(8'($urandom_range(255)), 1'b1);
      send_noise_header();
    end else if (pick < 85) begin
      case ($urandom_range(2))
        0: send_header(board.sync_reg ^ 16'($urandom_range(1, 65535)),
                       8'($urandom_range(255)), 16'($urandom_range(65535)),
                       1'($urandom_range(1)), 16'($urandom_range(65535)));
        1: begin
          if (m == 65535 || $urandom_range(1) == 0) len = 0;
          else len = $urandom_range(m + 1, 65535);
          send_header(board.sync_reg, 8'($urandom_range(255)), 16'(len),
                      1'($urandom_range(1)), 16'($urandom_range(65535)));
        end
        default: send_header(board.sync_reg, 8'($urandom_range(255)),
                             16'($urandom_range(1, m)), 1'b0,
                             16'($urandom_range(65535)));
      endcase
    end else if (pick < 95) begin
      send_noise_header();
    end else begin
      // stray bytes are only ignored, so they do not count
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: reset, directed requests, then six random segments, each
  // under its own register setting. Idling: sender 35 / receiver 47 for the
  // first two, swapped for the next two, none for the last two.
  // --------------------------------------------------------------------------
  initial begin
    logic [15:0] seg_sync;
    logic [15:0] seg_max;
    board = new();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();

    for (int seg = 0; seg < 6; seg++) begin
      drain_results();
      case (seg)
        0: begin
          seg_sync = 16'($urandom_range(65535));
          seg_max  = MAX_LEN_RST;
        end
        1: begin
          seg_sync = 16'hFFFF;
          seg_max  = 16'd1;
        end
        2: begin
          seg_sync = 16'h0000;
          seg_max  = 16'hFFFF;
        end
        3: begin
          seg_sync = 16'($urandom_range(65535));
          seg_max  = 16'($urandom_range(2, 40));
        end
        4: begin
          seg_sync = 16'($urandom_range(65535));
          seg_max  = 16'($urandom_range(1, 65535));
        end
        default: begin
          seg_sync = 16'($urandom_range(65535));
          seg_max  = 16'($urandom_range(12, 300));
        end
      endcase
      if (seg < 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 47;
      end else if (seg < 4) begin
        send_idle_pct = 47;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_registers(seg_sync, seg_max);
      counted_items = 0;
      while (counted_items < SEGMENT_ITEMS) begin
        // now and then hold off until the block has answered everything
        if ($urandom_range(199) == 0) drain_results();
        send_random_sequence();
      end
    end

    drain_results();
    if (board.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
